/* sv/rdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and constants of the restricted deque
// Operation and status codes, controller states and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int DATA_BITS_DEF = 32;
  localparam int VALUE_W       = 32;
  localparam int OPCODE_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REM_FRONT = 2'd2,
    OP_REM_BACK  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_DENIED = 2'd3
  } status_t;

  typedef enum logic {
    MODE_IN_RESTRICTED  = 1'b0,
    MODE_OUT_RESTRICTED = 1'b1
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/rdq_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_ifs: request and result channels of the restricted deque
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface rdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rdq_pkg::OPCODE_W-1:0]   opcode;
  logic signed [rdq_pkg::VALUE_W-1:0]    value_in;

  modport source (output valid, output opcode, output value_in, input ready);
  modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface rdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rdq_pkg::VALUE_W-1:0]    value_out;
  logic        [rdq_pkg::STATUS_W-1:0]   status;
  logic        [rdq_pkg::FILL_W-1:0]     fill_count;

  modport source (output valid, output value_out, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input value_out, input status, input fill_count,
                  output ready);
endinterface
`default_nettype wire

/* sv/rdq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_ctrl: request sequencing for the restricted deque
// Takes a request, moves to the load state while the entry is read and loads
// the result register, which then holds its result until the consumer takes it.
// ----------------------------------------------------------------------------
module rdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rdq_pkg::cmd_t      cmd
);
  import rdq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = !out_valid_r || out_ready;
        cmd.accept = accept;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_LOAD))
    else $error("accepted request not followed by a result load");

  a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r || $past(out_ready))
    else $error("result register loaded while an untaken result was held");
`endif

endmodule
`default_nettype wire

/* sv/rdq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_datapath: ring buffer, pointers and result register of the deque
// Decodes the operation against the mode and fill state, moves one pointer
// when the operation succeeds, writes or reads one entry and forms the result.
// ----------------------------------------------------------------------------
module rdq_datapath #(
  parameter int DEPTH     = rdq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = rdq_pkg::DATA_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rdq_pkg::cmd_t                       cmd,
  input  wire logic                                cfg_wr_en,
  input  wire logic                                cfg_wr_data,
  input  wire logic        [rdq_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic signed [rdq_pkg::VALUE_W-1:0]  in_value,
  output logic signed      [rdq_pkg::VALUE_W-1:0]  out_value,
  output logic             [rdq_pkg::STATUS_W-1:0] out_status,
  output logic             [rdq_pkg::FILL_W-1:0]   out_fill
);
  import rdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WX = (DATA_BITS > VALUE_W) ? DATA_BITS : VALUE_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [DATA_BITS-1:0] mem [DEPTH];

  logic [AW-1:0] front_r, front_nxt, back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;
  mode_t         mode_r;
  status_t       res_status_r, status_nxt;
  logic          res_take_r, take_nxt;
  logic [DATA_BITS-1:0] rd_data_r;

  logic signed [VALUE_W-1:0]  value_out_r;
  status_t                    status_out_r;
  logic        [FILL_W-1:0]   fill_out_r;

  logic [AW-1:0] front_up, front_dn, back_up, back_dn;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  logic          refused;
  op_t           op;
  logic [WX-1:0]        in_ext;
  logic [DATA_BITS-1:0] wr_data;
  logic signed [WX-1:0] rd_ext;

  assign op       = op_t'(in_opcode);
  assign front_up = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dn = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign back_up  = (back_r == LAST_IDX) ? '0 : back_r + AW'(1);
  assign back_dn  = (back_r == '0) ? LAST_IDX : back_r - AW'(1);
  assign refused  = (mode_r == MODE_IN_RESTRICTED) ? (op == OP_INS_FRONT)
                                                   : (op == OP_REM_BACK);
  assign in_ext   = WX'($unsigned(in_value));
  assign wr_data  = in_ext[DATA_BITS-1:0];
  assign rd_ext   = WX'($signed(rd_data_r));

  always_comb begin
    status_nxt = STAT_OK;
    take_nxt   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    rd_addr    = front_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    if (refused) begin
      status_nxt = STAT_DENIED;
    end else begin
      case (op)
        OP_INS_FRONT: begin
          if (count_r == FULL_CNT) begin
            status_nxt = STAT_FULL;
          end else begin
            front_nxt = front_dn;
            wr_addr   = front_dn;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_INS_BACK: begin
          if (count_r == FULL_CNT) begin
            status_nxt = STAT_FULL;
          end else begin
            back_nxt  = back_up;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REM_FRONT: begin
          if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
          end else begin
            front_nxt = front_up;
            take_nxt  = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_REM_BACK: begin
          if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
          end else begin
            back_nxt  = back_dn;
            rd_addr   = back_dn;
            take_nxt  = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = STAT_DENIED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
      mode_r  <= MODE_IN_RESTRICTED;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_t'(cfg_wr_data);
      end
      if (cmd.accept) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r    <= mem[rd_addr];
      res_status_r <= status_nxt;
      res_take_r   <= take_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_out_r  <= res_take_r ? rd_ext[VALUE_W-1:0] : '0;
      status_out_r <= res_status_r;
      fill_out_r   <= FILL_W'(count_r);
    end
  end

  assign out_value  = value_out_r;
  assign out_status = status_out_r;
  assign out_fill   = fill_out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds the buffer depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (front_r == back_r))
    else $error("pointers disagree with an empty or full buffer");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && res_status_r == STAT_FULL) |-> (count_r == FULL_CNT))
    else $error("insert refused as full while the buffer was not full");
`endif

endmodule
`default_nettype wire

/* sv/restricted_deque_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// restricted_deque_top: input- or output-restricted double-ended queue
// Ring buffer of signed words with front and back insert and removal.
// ----------------------------------------------------------------------------
// When a request is taken, a pointer moves and one entry of the ring buffer
// is written or read; the registered read port feeds the load state, in
// which the result register is loaded. A new request is taken only after
// the result of the last one is loaded, and a held result stalls the next
// request only until it is taken. Each request yields exactly one result
// with the removed word, a status and the new fill count. The mode
// register must be written only while no request is in flight. Entries
// never written read as undefined, but a removal only reaches written
// entries.
// ----------------------------------------------------------------------------
module restricted_deque_top #(
  parameter int DEPTH     = rdq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = rdq_pkg::DATA_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdq_in_if.sink     in_ch,
  rdq_out_if.source  out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);
  import rdq_pkg::*;

  cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rdq_datapath #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_opcode   (in_ch.opcode),
    .in_value    (in_ch.value_in),
    .out_value   (out_ch.value_out),
    .out_status  (out_ch.status),
    .out_fill    (out_ch.fill_count)
  );

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the restricted deque
// Drives front and back insert and removal requests under both restriction
// modes and predicts every result with a ring-buffer model. Each result is
// compared field by field with the oldest prediction. Both channels idle at
// random except in the last phase.
// ----------------------------------------------------------------------------
module tb;
  import rdq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;

  class deque_scoreboard;
    typedef struct {
      logic signed [VALUE_W-1:0] value;
      status_t                   status;
      logic [FILL_W-1:0]         fill;
    } deque_result_t;

    deque_result_t             pending_results[$];
    logic signed [VALUE_W-1:0] slots[DEPTH];
    int                        head;
    int                        tail;
    int                        held;
    mode_t                     mode;
    int                        mismatches;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      mode = MODE_IN_RESTRICTED;
      mismatches = 0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(op_t op, logic signed [VALUE_W-1:0] word);
      deque_result_t r;
      r.value = '0;
      r.status = STAT_OK;
      if ((mode == MODE_IN_RESTRICTED && op == OP_INS_FRONT) ||
          (mode == MODE_OUT_RESTRICTED && op == OP_REM_BACK)) begin
        r.status = STAT_DENIED;
      end else if (op == OP_INS_FRONT || op == OP_INS_BACK) begin
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (op == OP_INS_FRONT) begin
          head = (head + DEPTH - 1) % DEPTH;
          slots[head] = word;
          held++;
        end else begin
          slots[tail] = word;
          tail = (tail + 1) % DEPTH;
          held++;
        end
      end else if (held == 0) begin
        r.status = STAT_EMPTY;
      end else if (op == OP_REM_FRONT) begin
        r.value = slots[head];
        head = (head + 1) % DEPTH;
        held--;
      end else begin
        tail = (tail + DEPTH - 1) % DEPTH;
        r.value = slots[tail];
        held--;
      end
      r.fill = held[FILL_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] value,
                               logic [STATUS_W-1:0] status,
                               logic [FILL_W-1:0] fill);
      deque_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d fill %0d",
                 $time, value, status, fill);
        mismatches++;
        return;
      end
      r = pending_results.pop_front();
      if (value !== r.value) begin
        $display("%0t: value_out mismatch: expected %0d, actual %0d",
                 $time, r.value, value);
        mismatches++;
      end
      if (status !== r.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, r.status, status);
        mismatches++;
      end
      if (fill !== r.fill) begin
        $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                 $time, r.fill, fill);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic idle_on;
  mode_t cur_mode;
  int cycles;
  deque_scoreboard sb = new();

  rdq_in_if  in_bus();
  rdq_out_if out_bus();

  restricted_deque_top #(
    .DEPTH(DEPTH),
    .DATA_BITS(VALUE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.value_out, out_bus.status, out_bus.fill_count);
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(op_t'(in_bus.opcode), in_bus.value_in);
      end
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(op_t op, logic signed [VALUE_W-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.value_in <= word;
    @(posedge clk iff (in_bus.ready === 1'b1));
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
    sb.set_mode(m);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t pick_op(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return (cur_mode == MODE_IN_RESTRICTED) ? OP_INS_FRONT : OP_REM_BACK;
    end
    if ($urandom_range(0, 99) < insert_pct) begin
      if (cur_mode == MODE_IN_RESTRICTED) return OP_INS_BACK;
      return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
    end
    if (cur_mode == MODE_OUT_RESTRICTED) return OP_REM_FRONT;
    return $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_BACK;
  endfunction

  initial begin
    int insert_pct;
    idle_on = 1'b1;
    cur_mode = MODE_IN_RESTRICTED;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.opcode <= OP_INS_BACK;
    in_bus.value_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_IN_RESTRICTED);
    send_request(OP_REM_FRONT, $urandom);
    send_request(OP_REM_BACK, $urandom);
    send_request(OP_INS_FRONT, 32'sh12345678);
    send_request(OP_INS_BACK, 32'sh7fffffff);
    send_request(OP_INS_BACK, 32'sh80000000);
    send_request(OP_REM_BACK, $urandom);
    send_request(OP_REM_FRONT, $urandom);
    send_request(OP_REM_FRONT, $urandom);

    write_mode(MODE_OUT_RESTRICTED);
    send_request(OP_REM_BACK, $urandom);
    send_request(OP_INS_FRONT, 32'shaaaaaaaa);
    send_request(OP_INS_BACK, 32'sh55555555);
    send_request(OP_INS_FRONT, -32'sd1);
    send_request(OP_REM_BACK, $urandom);
    send_request(OP_REM_FRONT, $urandom);
    send_request(OP_REM_FRONT, $urandom);
    send_request(OP_REM_FRONT, $urandom);
    send_request(OP_REM_FRONT, $urandom);

    for (int phase = 0; phase < 6; phase++) begin
      write_mode((phase % 2 == 0) ? MODE_IN_RESTRICTED : MODE_OUT_RESTRICTED);
      for (int stretch = 0; stretch < 5; stretch++) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
        idle_on = (phase == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
        for (int n = 0; n < 32; n++) begin
          send_request(pick_op(insert_pct), random_word());
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
